// ===== hdl/openpgp_packet_header_framer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// OpenPGP packet header framer - assertion macros
// Clocked assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef OPENPGP_PACKET_HEADER_FRAMER_UNIT_DEFINES_SVH
`define OPENPGP_PACKET_HEADER_FRAMER_UNIT_DEFINES_SVH

// property sampled on clk, off while in reset
`define OPHF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication of the next-cycle form
`define OPHF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ophf_pkg.sv =====
// ----------------------------------------------------------------------------
// OpenPGP packet header framer - package
// Shared widths, result codes and the packet class lookup.
// ----------------------------------------------------------------------------
package ophf_pkg;

	localparam int LENGTH_WIDTH = 32;
	localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF >> (32 - LENGTH_WIDTH);

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_BODY   = 2'd1;
	localparam logic [1:0] KIND_DROP   = 2'd2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_TAG  = 2'd1;
	localparam logic [1:0] ERR_HDR  = 2'd2;
	localparam logic [1:0] ERR_BODY = 2'd3;

	localparam logic [1:0] CLASS_OTHER  = 2'd0;
	localparam logic [1:0] CLASS_SIG    = 2'd1;
	localparam logic [1:0] CLASS_PUBKEY = 2'd2;
	localparam logic [1:0] CLASS_UID    = 2'd3;

	localparam logic [5:0] TAG_SIG    = 6'd2;
	localparam logic [5:0] TAG_PUBKEY = 6'd6;
	localparam logic [5:0] TAG_UID    = 6'd13;

	function automatic logic [1:0] class_of(logic [5:0] t);
		logic [1:0] c;
		c = CLASS_OTHER;
		if (t == TAG_SIG)
			c = CLASS_SIG;
		else if (t == TAG_PUBKEY)
			c = CLASS_PUBKEY;
		else if (t == TAG_UID)
			c = CLASS_UID;
		return c;
	endfunction

	function automatic logic [31:0] sat_len(logic [31:0] v);
		return (v > LEN_MAX) ? LEN_MAX : v;
	endfunction

endpackage

// ===== hdl/openpgp_packet_header_framer_unit.sv =====
// ----------------------------------------------------------------------------
// OpenPGP packet header framer
// Frames OpenPGP packets in a byte stream and tags every byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one buffer byte per beat, data_byte with
//   last_byte set on the final byte of the buffer.
//   Output channel (out_valid/out_stall): exactly one result beat per input
//   beat, in order: byte kind, byte passed through, packet type and class,
//   decoded length, unknown-length flag, header/packet end marks, error code.
//   An accepted beat goes through the input register, then the result
//   register, before it shows on the output.
//   Throughput: one beat per cycle without a stall; the header decode and body
//   count are a single pass through the framing state, updated once per beat.
//   Receiver stall: the result register holds; the input register then fills
//   and in_stall rises, so at most two beats sit inside the block.
//   Reset: all pipeline valids clear, the framer waits for a tag byte.
//   Errors drop the rest of the buffer until last_byte.
// ----------------------------------------------------------------------------
module openpgp_packet_header_framer_unit import ophf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  byte_kind,
	output logic [7:0]  body_byte,
	output logic [5:0]  packet_type,
	output logic [1:0]  packet_class,
	output logic [31:0] packet_length,
	output logic        length_unknown,
	output logic        header_done,
	output logic        packet_end,
	output logic [1:0]  error_code
);

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_NEWLEN  = 3'd1,
		PH_NEWLEN2 = 3'd2,
		PH_MULTI   = 3'd3,
		PH_BODY    = 3'd4,
		PH_DROP    = 3'd5
	} phase_t;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// framing state
	phase_t      phase_q;
	logic [5:0]  type_q;
	logic [31:0] acc_q;
	logic [2:0]  lbl_q;
	logic [31:0] body_q;

	// result register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [5:0]  ptype_q;
	logic [1:0]  pclass_q;
	logic [31:0] plen_q;
	logic        unk_q;
	logic        hd_q;
	logic        pend_q;
	logic [1:0]  err_q;

	logic out_free;
	logic adv;
	logic in_acc;

	// next state / result
	phase_t      phase_d;
	logic [5:0]  type_d;
	logic [31:0] acc_d;
	logic [2:0]  lbl_d;
	logic [31:0] body_d;
	logic [1:0]  o_kind;
	logic [31:0] o_len;
	logic        o_unk;
	logic        o_hd;
	logic        o_end;
	logic [1:0]  o_err;
	logic        fin;
	logic [31:0] fin_len;
	logic        fin_unk;
	logic [31:0] fin_sat;
	logic        raise;
	logic [1:0]  raise_code;
	logic [31:0] acc_shift;
	logic [2:0]  lbl_dec;
	logic [31:0] body_dec;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		phase_d    = phase_q;
		type_d     = type_q;
		acc_d      = acc_q;
		lbl_d      = lbl_q;
		body_d     = body_q;
		o_kind     = KIND_HEADER;
		o_len      = '0;
		o_unk      = 1'b0;
		o_hd       = 1'b0;
		o_end      = 1'b0;
		o_err      = ERR_NONE;
		fin        = 1'b0;
		fin_len    = '0;
		fin_unk    = 1'b0;
		raise      = 1'b0;
		raise_code = ERR_NONE;
		acc_shift  = {acc_q[23:0], byte_s1};
		lbl_dec    = lbl_q - 3'd1;
		body_dec   = (body_q != '0) ? body_q - 32'd1 : body_q;

		unique case (phase_q)
			PH_DROP: begin
				o_kind = KIND_DROP;
				if (last_s1)
					phase_d = PH_TAG;
			end
			PH_NEWLEN: begin
				if (byte_s1 < 8'd192) begin
					fin     = 1'b1;
					fin_len = {24'd0, byte_s1};
				end else if (byte_s1 < 8'd224) begin
					acc_d = {19'd0, byte_s1[4:0], 8'd0};
					if (last_s1) begin
						raise      = 1'b1;
						raise_code = ERR_HDR;
					end else begin
						phase_d = PH_NEWLEN2;
					end
				end else if (byte_s1 == 8'd255) begin
					acc_d = '0;
					lbl_d = 3'd4;
					if (last_s1) begin
						raise      = 1'b1;
						raise_code = ERR_HDR;
					end else begin
						phase_d = PH_MULTI;
					end
				end else begin
					fin     = 1'b1;
					fin_unk = 1'b1;
				end
			end
			PH_NEWLEN2: begin
				fin     = 1'b1;
				fin_len = acc_q + {24'd0, byte_s1} + 32'd192;
			end
			PH_MULTI: begin
				acc_d = acc_shift;
				lbl_d = lbl_dec;
				if (lbl_dec == 3'd0) begin
					fin     = 1'b1;
					fin_len = acc_shift;
				end else if (last_s1) begin
					raise      = 1'b1;
					raise_code = ERR_HDR;
				end
			end
			PH_BODY: begin
				o_kind = KIND_BODY;
				o_len  = acc_q;
				body_d = body_dec;
				if (body_dec == '0) begin
					o_end   = 1'b1;
					phase_d = PH_TAG;
				end else if (last_s1) begin
					raise      = 1'b1;
					raise_code = ERR_BODY;
				end
			end
			default: begin
				// tag byte; unused codes land here too
				phase_d = PH_TAG;
				acc_d   = '0;
				if (!byte_s1[7]) begin
					type_d     = '0;
					raise      = 1'b1;
					raise_code = ERR_TAG;
				end else if (byte_s1[6]) begin
					type_d = byte_s1[5:0];
					if (last_s1) begin
						raise      = 1'b1;
						raise_code = ERR_HDR;
					end else begin
						phase_d = PH_NEWLEN;
					end
				end else begin
					type_d = {2'd0, byte_s1[5:2]};
					if (byte_s1[1:0] == 2'd3) begin
						fin     = 1'b1;
						fin_unk = 1'b1;
					end else begin
						lbl_d = 3'b001 << byte_s1[1:0];
						if (last_s1) begin
							raise      = 1'b1;
							raise_code = ERR_HDR;
						end else begin
							phase_d = PH_MULTI;
						end
					end
				end
			end
		endcase

		fin_sat = sat_len(fin_len);
		if (fin) begin
			acc_d = fin_sat;
			o_len = fin_sat;
			o_unk = fin_unk;
			o_hd  = 1'b1;
			if (fin_sat == '0) begin
				o_end   = 1'b1;
				phase_d = PH_TAG;
			end else if (last_s1) begin
				raise      = 1'b1;
				raise_code = ERR_BODY;
			end else begin
				body_d  = fin_sat;
				phase_d = PH_BODY;
			end
		end

		if (raise) begin
			o_err   = raise_code;
			phase_d = last_s1 ? PH_TAG : PH_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_TAG;
			type_q      <= '0;
			acc_q       <= '0;
			lbl_q       <= '0;
			body_q      <= '0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			out_valid_q <= adv || (out_valid_q && out_stall);
			if (adv) begin
				phase_q <= phase_d;
				type_q  <= type_d;
				acc_q   <= acc_d;
				lbl_q   <= lbl_d;
				body_q  <= body_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (adv) begin
			kind_q   <= o_kind;
			byte_q   <= byte_s1;
			ptype_q  <= (o_kind == KIND_DROP) ? 6'd0 : type_d;
			pclass_q <= (o_kind == KIND_DROP) ? CLASS_OTHER : class_of(type_d);
			plen_q   <= o_len;
			unk_q    <= o_unk;
			hd_q     <= o_hd;
			pend_q   <= o_end;
			err_q    <= o_err;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_kind      = kind_q;
	assign body_byte      = byte_q;
	assign packet_type    = ptype_q;
	assign packet_class   = pclass_q;
	assign packet_length  = plen_q;
	assign length_unknown = unk_q;
	assign header_done    = hd_q;
	assign packet_end     = pend_q;
	assign error_code     = err_q;

endmodule

// ===== hdl/ophf_checker.sv =====
// ----------------------------------------------------------------------------
// OpenPGP packet header framer - port checker
// Watches the top-level ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
`include "openpgp_packet_header_framer_unit_defines.svh"

module ophf_checker import ophf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  byte_kind,
	input logic [7:0]  body_byte,
	input logic [5:0]  packet_type,
	input logic [1:0]  packet_class,
	input logic [31:0] packet_length,
	input logic        length_unknown,
	input logic        header_done,
	input logic        packet_end,
	input logic [1:0]  error_code
);

	logic [41:0] held_fields;
	logic        drop_beat;
	logic        drop_zero;
	logic        body_beat;
	logic        body_clean;
	logic        hdr_body_err;

	assign held_fields  = {byte_kind, body_byte, packet_length};
	assign drop_beat    = out_valid && byte_kind == KIND_DROP;
	assign drop_zero    = error_code == ERR_NONE && packet_type == 6'd0 &&
		packet_class == CLASS_OTHER && !header_done && !packet_end &&
		!length_unknown && packet_length == 32'd0;
	assign body_beat    = out_valid && byte_kind == KIND_BODY;
	assign body_clean   = !header_done && !length_unknown &&
		error_code != ERR_TAG && error_code != ERR_HDR;
	assign hdr_body_err = out_valid && byte_kind == KIND_HEADER && error_code == ERR_BODY;

	`OPHF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(held_fields), "stalled result beat changed")

	`OPHF_ASSERT(a_drop_clean, !drop_beat || drop_zero, "dropped beat carries fields")

	`OPHF_ASSERT(a_body_no_hdr, !body_beat || body_clean, "body beat with header marks")

	`OPHF_ASSERT(a_zero_len_end, !(out_valid && header_done && packet_length == 32'd0) || packet_end, "zero-length header without packet end")

	`OPHF_ASSERT(a_trunc_hdr_beat, !hdr_body_err || header_done, "body truncation on a non-final header beat")

endmodule

bind openpgp_packet_header_framer_unit ophf_checker u_ophf_checker (.*);
